// ----- sv/paged_memory_cache_policy_unit_defines.svh -----
// assertion macros for the paged memory cache policy unit
// no dependencies; define ASSERT_OFF to drop every check
`ifndef PAGED_MEMORY_CACHE_POLICY_UNIT_DEFINES_SVH
`define PAGED_MEMORY_CACHE_POLICY_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define PMCP_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("pmcp check failed");
`define PMCP_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("pmcp check failed");
`else
`define PMCP_ASSERT_SAME(label, clk, rst_n, a, b)
`define PMCP_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- sv/pmcp_pkg.sv -----
// shared types, codes and defaults of the paged memory cache policy unit
// no dependencies
package pmcp_pkg;

    localparam int CODE_SLOTS_DEF  = 64;
    localparam int DATA_SLOTS_DEF  = 16;
    localparam int STACK_SLOTS_DEF = 16;
    localparam int PAGE_BYTES_DEF  = 256;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODE_START  = 3'd0,
        CFG_CODE_END    = 3'd1,
        CFG_DATA_START  = 3'd2,
        CFG_DATA_END    = 3'd3,
        CFG_STACK_START = 3'd4,
        CFG_STACK_END   = 3'd5,
        CFG_BSS_START   = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_FETCH = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_CROSS    = 2'd1,
        STAT_CODE_WR  = 2'd2,
        STAT_NO_SECT  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SEC_CODE  = 2'd0,
        SEC_DATA  = 2'd1,
        SEC_STACK = 2'd2
    } t_region;

    typedef enum logic [1:0] {
        FILL_NONE  = 2'd0,
        FILL_RO    = 2'd1,
        FILL_RW    = 2'd2,
        FILL_ZERO  = 2'd3
    } t_fill;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PICK,
        ST_RESOLVE
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [2:0]  access_size;
        logic [15:0] random_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [1:0]  region;
        logic [5:0]  slot;
        logic [7:0]  page_offset;
        logic        writeback;
        logic [31:0] writeback_page;
        logic [1:0]  fill_action;
        logic [31:0] create_from;
        logic [31:0] create_to;
    } t_out_word;

    typedef struct packed {
        logic look;
        logic pick;
        logic wr;
    } t_row_ctl;

    typedef struct packed {
        logic hit;
        logic victim_used;
    } t_row_res;

endpackage

// ----- sv/pmcp_cell.sv -----
// one slot cell: page tag, used bit, compare and scan chain link
// depends on pmcp_pkg
module pmcp_cell
    import pmcp_pkg::*;
#(
    parameter int TAG_W = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [TAG_W-1:0] i_tag,
    input  logic             i_we,
    input  logic             i_done,
    output logic             o_done,
    output logic             o_stop,
    output logic             o_hit,
    output logic [TAG_W-1:0] o_tag,
    output logic             o_used
);

    logic [TAG_W-1:0] r_tag;
    logic             r_used;
    logic             match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_we) begin
            r_used <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_tag <= i_tag;
        end
    end

    assign match  = r_used && (r_tag == i_tag);
    assign o_hit  = !i_done && match;
    assign o_stop = !i_done && (match || !r_used);
    assign o_done = i_done || match || !r_used;
    assign o_tag  = r_tag;
    assign o_used = r_used;

endmodule

// ----- sv/pmcp_row.sv -----
// row of slot cells for one section, with scan result and victim choice
// depends on pmcp_pkg and pmcp_cell
module pmcp_row
    import pmcp_pkg::*;
#(
    parameter int N     = 16,
    parameter int TAG_W = 24,
    parameter int IDX_W = (N > 1) ? $clog2(N) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_row_ctl         i_ctl,
    input  logic [TAG_W-1:0] i_tag,
    input  logic [15:0]      i_rnd,
    output t_row_res         o_res,
    output logic [IDX_W-1:0] o_slot,
    output logic [TAG_W-1:0] o_victim_tag
);

    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N + 64'd1);

    logic [N:0]       done;
    logic [N-1:0]     stop;
    logic [N-1:0]     hitv;
    logic [N-1:0]     usedv;
    logic [TAG_W-1:0] tagv [N];
    logic [IDX_W-1:0] stop_idx;
    logic [48:0]      prod;
    logic [15:0]      rem;

    logic             r_hit;
    logic             r_full;
    logic [IDX_W-1:0] r_stop;
    logic [15:0]      r_q;
    logic [IDX_W-1:0] r_slot;

    assign done[0] = 1'b0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        pmcp_cell #(.TAG_W(TAG_W)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tag  (i_tag),
            .i_we   (i_ctl.wr && (r_slot == IDX_W'(g))),
            .i_done (done[g]),
            .o_done (done[g+1]),
            .o_stop (stop[g]),
            .o_hit  (hitv[g]),
            .o_tag  (tagv[g]),
            .o_used (usedv[g])
        );
    end

    always_comb begin
        stop_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (stop[i]) begin
                stop_idx = stop_idx | IDX_W'(i);
            end
        end
    end

    assign prod = 49'(i_rnd) * 49'(RECIP);
    assign rem  = i_rnd - 16'(r_q * 16'(N));

    always_ff @(posedge i_clk) begin
        if (i_ctl.look) begin
            r_hit  <= |hitv;
            r_full <= !done[N];
            r_stop <= stop_idx;
            r_q    <= prod[47:32];
        end
        if (i_ctl.pick) begin
            r_slot <= r_full ? IDX_W'(rem) : r_stop;
        end
    end

    assign o_res.hit         = r_hit;
    assign o_res.victim_used = usedv[r_slot];
    assign o_slot            = r_slot;
    assign o_victim_tag      = tagv[r_slot];

endmodule

// ----- sv/paged_memory_cache_policy_unit.sv -----
// One access passes from acceptance to result through the check, pick and resolve
// states: the section and page check together with a scan of every section's row
// of slot cells, the victim pick (random value modulo the slot count by reciprocal
// multiply), and the update of slots and marks into the output register. A new
// access is taken once the previous one has reached the output register; that
// register lets the next access start while a result waits.
// top level; depends on pmcp_pkg, pmcp_row and the defines header
`include "paged_memory_cache_policy_unit_defines.svh"
module paged_memory_cache_policy_unit
    import pmcp_pkg::*;
#(
    parameter int CODE_SLOTS  = CODE_SLOTS_DEF,
    parameter int DATA_SLOTS  = DATA_SLOTS_DEF,
    parameter int STACK_SLOTS = STACK_SLOTS_DEF,
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out
);

    localparam int SH      = $clog2(PAGE_BYTES);
    localparam int TAG_W   = 32 - SH;
    localparam int CODE_IW = (CODE_SLOTS > 1) ? $clog2(CODE_SLOTS) : 1;
    localparam int DATA_IW = (DATA_SLOTS > 1) ? $clog2(DATA_SLOTS) : 1;
    localparam int STK_IW  = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;

    t_state      r_state, n_state;
    t_in_word    r_in;
    t_status     r_status;
    t_region     r_sec;
    t_out_word   r_out, n_out;
    logic        r_out_valid;
    logic [31:0] r_code_start, r_code_end, r_data_start, r_data_end;
    logic [31:0] r_stack_start, r_stack_end;
    logic [31:0] r_dhm, n_dhm, r_slm, n_slm;

    logic        in_acc, out_free, do_res;
    t_row_ctl    ctl_c, ctl_d, ctl_s;
    t_row_res    res_c, res_d, res_s;
    logic [CODE_IW-1:0] slot_c;
    logic [DATA_IW-1:0] slot_d;
    logic [STK_IW-1:0]  slot_s;
    logic [TAG_W-1:0]   vtag_d, vtag_s;

    logic [TAG_W-1:0] tag;
    logic [31:0]      page, last;
    logic [2:0]       size;
    logic             is_fetch, is_write, wr_c, wr_d, wr_s;
    t_status          chk_status;
    t_region          chk_sec;

    assign tag  = r_in.address[31:SH];
    assign page = {tag, SH'(0)};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (in_acc) n_state = ST_CHECK;
            ST_CHECK:   n_state = ST_PICK;
            ST_PICK:    n_state = ST_RESOLVE;
            ST_RESOLVE: if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        ctl_c      = '0;
        ctl_d      = '0;
        ctl_s      = '0;
        do_res     = 1'b0;
        case (r_state)
            ST_IDLE:    o_in_stall = 1'b0;
            ST_CHECK: begin
                ctl_c.look = 1'b1;
                ctl_d.look = 1'b1;
                ctl_s.look = 1'b1;
            end
            ST_PICK: begin
                ctl_c.pick = 1'b1;
                ctl_d.pick = 1'b1;
                ctl_s.pick = 1'b1;
            end
            ST_RESOLVE: do_res = out_free;
            default:    o_in_stall = 1'b1;
        endcase
        ctl_c.wr = do_res && wr_c;
        ctl_d.wr = do_res && wr_d;
        ctl_s.wr = do_res && wr_s;
    end

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // page and section check
    always_comb begin
        is_fetch   = (r_in.kind == KIND_FETCH);
        is_write   = (r_in.kind == KIND_WRITE);
        size       = is_fetch ? 3'd4 : r_in.access_size;
        last       = r_in.address + 32'(size) - 32'd1;
        chk_status = STAT_OK;
        chk_sec    = SEC_CODE;
        if (last[31:SH] != tag) begin
            chk_status = STAT_CROSS;
        end else if (is_fetch) begin
            chk_sec = SEC_CODE;
        end else if (page >= r_code_start && page < r_code_end) begin
            if (is_write) chk_status = STAT_CODE_WR;
        end else if (page >= r_data_start && page < r_data_end) begin
            chk_sec = SEC_DATA;
        end else if (page >= r_stack_start && page < r_stack_end) begin
            chk_sec = SEC_STACK;
        end else begin
            chk_status = STAT_NO_SECT;
        end
    end

    pmcp_row #(.N(CODE_SLOTS), .TAG_W(TAG_W), .IDX_W(CODE_IW)) u_code_row (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_c), .i_tag(tag),
        .i_rnd(r_in.random_value), .o_res(res_c), .o_slot(slot_c),
        .o_victim_tag()
    );

    pmcp_row #(.N(DATA_SLOTS), .TAG_W(TAG_W), .IDX_W(DATA_IW)) u_data_row (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_d), .i_tag(tag),
        .i_rnd(r_in.random_value), .o_res(res_d), .o_slot(slot_d),
        .o_victim_tag(vtag_d)
    );

    pmcp_row #(.N(STACK_SLOTS), .TAG_W(TAG_W), .IDX_W(STK_IW)) u_stack_row (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_s), .i_tag(tag),
        .i_rnd(r_in.random_value), .o_res(res_s), .o_slot(slot_s),
        .o_victim_tag(vtag_s)
    );

    // result and mark update
    always_comb begin
        n_out             = '0;
        n_out.page_offset = 8'(r_in.address[SH-1:0]);
        n_out.status      = r_status;
        n_dhm             = r_dhm;
        n_slm             = r_slm;
        wr_c              = 1'b0;
        wr_d              = 1'b0;
        wr_s              = 1'b0;
        if (r_status == STAT_OK) begin
            n_out.region = r_sec;
            case (r_sec)
                SEC_CODE: begin
                    n_out.hit  = res_c.hit;
                    n_out.slot = 6'(slot_c);
                    if (!res_c.hit) begin
                        wr_c              = 1'b1;
                        n_out.fill_action = FILL_RO;
                    end
                end
                SEC_DATA: begin
                    n_out.hit  = res_d.hit;
                    n_out.slot = 6'(slot_d);
                    if (!res_d.hit) begin
                        wr_d                 = 1'b1;
                        n_out.writeback      = res_d.victim_used;
                        n_out.writeback_page = res_d.victim_used ?
                                               {vtag_d, SH'(0)} : 32'd0;
                        if (page >= r_dhm) begin
                            n_out.create_from = r_dhm;
                            n_out.create_to   = page + 32'(PAGE_BYTES);
                            n_dhm             = page + 32'(PAGE_BYTES);
                            n_out.fill_action = FILL_ZERO;
                        end else begin
                            n_out.fill_action = FILL_RW;
                        end
                    end
                end
                SEC_STACK: begin
                    n_out.hit  = res_s.hit;
                    n_out.slot = 6'(slot_s);
                    if (!res_s.hit) begin
                        wr_s                 = 1'b1;
                        n_out.writeback      = res_s.victim_used;
                        n_out.writeback_page = res_s.victim_used ?
                                               {vtag_s, SH'(0)} : 32'd0;
                        if (page < r_slm) begin
                            n_out.create_from = page;
                            n_out.create_to   = r_slm;
                            n_slm             = page;
                            n_out.fill_action = FILL_ZERO;
                        end else begin
                            n_out.fill_action = FILL_RW;
                        end
                    end
                end
                default: n_out.region = SEC_CODE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_res) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) r_in <= i_in;
        if (r_state == ST_CHECK) begin
            r_status <= chk_status;
            r_sec    <= chk_sec;
        end
        if (do_res) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_start  <= '0;
            r_code_end    <= '0;
            r_data_start  <= '0;
            r_data_end    <= '0;
            r_stack_start <= '0;
            r_stack_end   <= '0;
            r_dhm         <= '0;
            r_slm         <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CODE_START:  r_code_start  <= i_cfg_data;
                CFG_CODE_END:    r_code_end    <= i_cfg_data;
                CFG_DATA_START:  r_data_start  <= i_cfg_data;
                CFG_DATA_END:    r_data_end    <= i_cfg_data;
                CFG_STACK_START: r_stack_start <= i_cfg_data;
                CFG_STACK_END: begin
                    r_stack_end <= i_cfg_data;
                    r_slm       <= {i_cfg_data[31:SH], SH'(0)};
                end
                CFG_BSS_START:   r_dhm <= {i_cfg_data[31:SH], SH'(0)};
                default:         r_dhm <= r_dhm;
            endcase
        end else if (do_res) begin
            r_dhm <= n_dhm;
            r_slm <= n_slm;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `PMCP_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_state == ST_CHECK)
    `PMCP_ASSERT_NEXT(a_pick_resolves, i_clk, i_rst_n, r_state == ST_PICK, r_state == ST_RESOLVE)
    `PMCP_ASSERT_SAME(a_error_clean, i_clk, i_rst_n, o_out_valid && o_out.status != STAT_OK, !o_out.hit && o_out.fill_action == FILL_NONE && o_out.create_to == 32'd0)

endmodule

// ----- dv/tb_paged_memory_cache_policy_unit.sv -----
// testbench for the paged memory cache policy unit: random and directed accesses
// checked word by word against a behavioral model of the slot and mark policy
// depends on pmcp_pkg and paged_memory_cache_policy_unit
module tb_paged_memory_cache_policy_unit;
    import pmcp_pkg::*;

    localparam int N_CODE = 64;
    localparam int N_DATA = 16;
    localparam int N_STACK = 16;
    localparam logic [31:0] PG = 32'd256;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_word i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_word o_out;

    paged_memory_cache_policy_unit u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // policy model state
    logic [31:0] sect_bound [7];
    logic [31:0] code_tag [N_CODE];
    logic code_used [N_CODE];
    logic [31:0] data_tag [N_DATA];
    logic data_used [N_DATA];
    logic [31:0] stack_tag [N_STACK];
    logic stack_used [N_STACK];
    int cur_code;
    logic cur_code_ok;
    logic [31:0] data_high, stack_low;

    t_in_word pending_q [$];
    t_out_word expected_q [$];
    int errors = 0;

    function automatic logic [31:0] page_base(logic [31:0] a);
        return a & ~(PG - 1);
    endfunction

    function automatic void policy_reset();
        for (int i = 0; i < 7; i++) sect_bound[i] = '0;
        for (int i = 0; i < N_CODE; i++) begin
            code_tag[i] = '0;
            code_used[i] = 1'b0;
        end
        for (int i = 0; i < N_DATA; i++) begin
            data_tag[i] = '0;
            data_used[i] = 1'b0;
        end
        for (int i = 0; i < N_STACK; i++) begin
            stack_tag[i] = '0;
            stack_used[i] = 1'b0;
        end
        cur_code = 0;
        cur_code_ok = 1'b0;
        data_high = '0;
        stack_low = '0;
    endfunction

    function automatic void policy_write(t_cfg_idx idx, logic [31:0] v);
        sect_bound[idx] = v;
        if (idx == CFG_STACK_END) stack_low = page_base(v);
        if (idx == CFG_BSS_START) data_high = page_base(v);
    endfunction

    function automatic bit in_sect(logic [31:0] a, t_cfg_idx lo, t_cfg_idx hi);
        return a >= sect_bound[lo] && a < sect_bound[hi];
    endfunction

    function automatic t_out_word policy_access(t_in_word w);
        t_out_word r;
        logic [1:0] kind;
        logic [31:0] sz, pg;
        logic [1:0] st;
        logic [7:0] off;
        int s;
        bit found;
        r = '0;
        kind = (w.kind == 2'd3) ? KIND_READ : w.kind;
        sz = (kind == KIND_FETCH) ? 32'd4 : 32'(w.access_size);
        pg = page_base(w.address);
        r.page_offset = w.address[7:0];
        if (page_base(w.address + sz - 1) != pg) begin
            r.status = STAT_CROSS;
        end else if (kind == KIND_FETCH || in_sect(pg, CFG_CODE_START, CFG_CODE_END)) begin
            if (kind == KIND_WRITE) begin
                r.status = STAT_CODE_WR;
            end else if (kind == KIND_FETCH && cur_code_ok && code_used[cur_code]
                         && code_tag[cur_code] == pg) begin
                r.hit = 1'b1;
                s = cur_code;
            end else begin
                found = 0;
                s = w.random_value % N_CODE;
                for (int i = 0; i < N_CODE; i++) begin
                    if (code_used[i] && code_tag[i] == pg) begin
                        s = i;
                        found = 1;
                        break;
                    end
                    if (!code_used[i]) begin
                        s = i;
                        break;
                    end
                end
                r.hit = found;
                if (!found) begin
                    code_tag[s] = pg;
                    code_used[s] = 1'b1;
                    r.fill_action = FILL_RO;
                    if (kind == KIND_FETCH) begin
                        cur_code = s;
                        cur_code_ok = 1'b1;
                    end
                end
            end
            r.slot = s[5:0];
        end else if (in_sect(pg, CFG_DATA_START, CFG_DATA_END)) begin
            r.region = SEC_DATA;
            found = 0;
            s = w.random_value % N_DATA;
            for (int i = 0; i < N_DATA; i++) begin
                if (data_used[i] && data_tag[i] == pg) begin
                    s = i;
                    found = 1;
                    break;
                end
                if (!data_used[i]) begin
                    s = i;
                    break;
                end
            end
            r.hit = found;
            r.slot = s[5:0];
            if (!found) begin
                if (data_used[s]) begin
                    r.writeback = 1'b1;
                    r.writeback_page = data_tag[s];
                end
                if (pg >= data_high) begin
                    r.create_from = data_high;
                    r.create_to = pg + PG;
                    data_high = pg + PG;
                    r.fill_action = FILL_ZERO;
                end else begin
                    r.fill_action = FILL_RW;
                end
                data_tag[s] = pg;
                data_used[s] = 1'b1;
            end
        end else if (in_sect(pg, CFG_STACK_START, CFG_STACK_END)) begin
            r.region = SEC_STACK;
            found = 0;
            s = w.random_value % N_STACK;
            for (int i = 0; i < N_STACK; i++) begin
                if (stack_used[i] && stack_tag[i] == pg) begin
                    s = i;
                    found = 1;
                    break;
                end
                if (!stack_used[i]) begin
                    s = i;
                    break;
                end
            end
            r.hit = found;
            r.slot = s[5:0];
            if (!found) begin
                if (stack_used[s]) begin
                    r.writeback = 1'b1;
                    r.writeback_page = stack_tag[s];
                end
                if (pg < stack_low) begin
                    r.create_from = pg;
                    r.create_to = stack_low;
                    stack_low = pg;
                    r.fill_action = FILL_ZERO;
                end else begin
                    r.fill_action = FILL_RW;
                end
                stack_tag[s] = pg;
                stack_used[s] = 1'b1;
            end
        end else begin
            r.status = STAT_NO_SECT;
        end
        if (r.status != STAT_OK) begin
            st = r.status;
            off = r.page_offset;
            r = '0;
            r.status = st;
            r.page_offset = off;
        end
        return r;
    endfunction

    // driver
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_q.push_back(policy_access(i_in));
                void'(pending_q.pop_front());
                in_gap = $urandom_range(0, 7);
                if ($urandom_range(0, 3) == 0) in_gap = 0;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (in_gap > 0) begin
                    in_gap = in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_q.size() > 0 &&
                             !(i_in_valid && !o_in_stall && pending_q.size() == 0)) begin
                    i_in_valid <= 1'b1;
                    i_in <= pending_q[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int out_wait = 0;
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected word %h", o_out);
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (o_out.status != e.status) begin
                        $error("status exp %0d got %0d", e.status, o_out.status); errors++;
                    end
                    if (o_out.hit != e.hit) begin
                        $error("hit exp %0d got %0d", e.hit, o_out.hit); errors++;
                    end
                    if (o_out.region != e.region) begin
                        $error("region exp %0d got %0d", e.region, o_out.region); errors++;
                    end
                    if (o_out.slot != e.slot) begin
                        $error("slot exp %0d got %0d", e.slot, o_out.slot); errors++;
                    end
                    if (o_out.page_offset != e.page_offset) begin
                        $error("page_offset exp %0d got %0d", e.page_offset,
                               o_out.page_offset); errors++;
                    end
                    if (o_out.writeback != e.writeback) begin
                        $error("writeback exp %0d got %0d", e.writeback, o_out.writeback);
                        errors++;
                    end
                    if (o_out.writeback_page != e.writeback_page) begin
                        $error("writeback_page exp %h got %h", e.writeback_page,
                               o_out.writeback_page); errors++;
                    end
                    if (o_out.fill_action != e.fill_action) begin
                        $error("fill_action exp %0d got %0d", e.fill_action,
                               o_out.fill_action); errors++;
                    end
                    if (o_out.create_from != e.create_from) begin
                        $error("create_from exp %h got %h", e.create_from,
                               o_out.create_from); errors++;
                    end
                    if (o_out.create_to != e.create_to) begin
                        $error("create_to exp %h got %h", e.create_to, o_out.create_to);
                        errors++;
                    end
                end
                out_wait = $urandom_range(0, 7);
                if ($urandom_range(0, 3) == 0) out_wait = 0;
            end
            if (out_wait > 0) begin
                out_wait = out_wait - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic reg_write(t_cfg_idx idx, logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        policy_write(idx, v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic add_word(logic [1:0] k, logic [31:0] a, logic [2:0] sz, logic [15:0] rv);
        t_in_word w;
        w.kind = k;
        w.address = a;
        w.access_size = sz;
        w.random_value = rv;
        pending_q.push_back(w);
    endtask

    // sections: code 0x10000.., data, stack, picks an address mostly inside them
    function automatic logic [31:0] pick_address(int pages);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 32'h0001_0000 + $urandom_range(0, pages * 256 - 1);
        if (r < 6) return 32'h0004_0000 + $urandom_range(0, pages * 256 - 1);
        if (r < 9) return 32'h0008_0000 - $urandom_range(1, pages * 256);
        return $urandom;
    endfunction

    task automatic random_phase(int n, int pages);
        logic [2:0] sz;
        for (int i = 0; i < n; i++) begin
            sz = ($urandom_range(0, 15) == 0) ? 3'($urandom) : 3'(1 << $urandom_range(0, 2));
            add_word(2'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2)),
                     pick_address(pages), sz, 16'($urandom));
        end
        drain();
    endtask

    task automatic set_sections(logic [31:0] cs, ce, ds, de, ss, se, bss);
        reg_write(CFG_CODE_START, cs);
        reg_write(CFG_CODE_END, ce);
        reg_write(CFG_DATA_START, ds);
        reg_write(CFG_DATA_END, de);
        reg_write(CFG_STACK_START, ss);
        reg_write(CFG_STACK_END, se);
        reg_write(CFG_BSS_START, bss);
    endtask

    initial begin
        policy_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: no sections configured, then extremes
        add_word(KIND_READ, 32'h0, 3'd1, 16'h0);
        add_word(KIND_FETCH, 32'hFFFF_FFFC, 3'd1, 16'hFFFF);
        add_word(KIND_FETCH, 32'hFFFF_FFFD, 3'd7, 16'h0);
        add_word(KIND_FETCH, 32'hFFFF_FF00, 3'd0, 16'h0);
        add_word(KIND_READ, 32'h0000_0100, 3'd0, 16'h0);
        add_word(KIND_READ, 32'h0000_01FF, 3'd2, 16'h0);
        add_word(2'd3, 32'h0000_01FF, 3'd1, 16'h0);
        drain();
        set_sections(32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0005_0000,
                     32'h0007_0000, 32'h0008_0000, 32'h0004_0380);
        add_word(KIND_WRITE, 32'h0001_0010, 3'd4, 16'h0);
        add_word(KIND_READ, 32'h0001_0010, 3'd4, 16'h0);
        add_word(KIND_FETCH, 32'h0001_0010, 3'd4, 16'h0);
        add_word(KIND_FETCH, 32'h0001_0014, 3'd4, 16'h0);
        add_word(KIND_WRITE, 32'h0004_0000, 3'd4, 16'h0);
        add_word(KIND_READ, 32'h0004_0800, 3'd2, 16'h0);
        add_word(KIND_WRITE, 32'h0007_FFFC, 3'd4, 16'h0);
        add_word(KIND_WRITE, 32'h0007_F000, 3'd1, 16'h0);
        add_word(KIND_READ, 32'h0007_FF00, 3'd1, 16'h0);
        add_word(KIND_READ, 32'h0003_0000, 3'd1, 16'h0);
        drain();
        random_phase(500, 24);
        // mark wrap: data section at the top of memory
        set_sections(32'h0, 32'h0, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF);
        add_word(KIND_WRITE, 32'hFFFF_FE00, 3'd4, 16'h0);
        add_word(KIND_READ, 32'hFFFF_F000, 3'd4, 16'h0);
        add_word(KIND_READ, 32'h0000_0000, 3'd4, 16'h0);
        drain();
        random_phase(150, 30);
        set_sections(32'h0001_0000, 32'h0001_4000, 32'h0004_0000, 32'h0004_4000,
                     32'h0007_C000, 32'h0008_0000, 32'h0004_0000);
        random_phase(450, 40);
        set_sections(32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                     32'h0, 32'hFFFF_FFFF, 32'h0);
        random_phase(450, 80);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
